// ===== rtl/core/cdq_pkg.sv =====
// shared types and constants for the circular double-ended queue
package cdq_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  localparam logic signed [WORD_W-1:0] EMPTY_VALUE = '1;

  // shift commands broadcast along the cell row
  typedef struct packed {
    logic shift_r;
    logic shift_l;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/cdq_if.sv =====
// operation and result channel interfaces
interface cdq_op_if;
  logic                                   valid;
  logic                                   ready;
  cdq_pkg::op_e                           op;
  logic signed [cdq_pkg::WORD_W-1:0]      data;

  modport source (output valid, output op, output data, input ready);
  modport sink   (input valid, input op, input data, output ready);
endinterface

interface cdq_res_if #(
  parameter int unsigned OCC_W = 5
);
  logic                                   valid;
  logic                                   ready;
  logic signed [cdq_pkg::WORD_W-1:0]      value;
  cdq_pkg::status_e                       status;
  logic [OCC_W-1:0]                       occupancy;

  modport source (output valid, output value, output status, output occupancy, input ready);
  modport sink   (input valid, input value, input status, input occupancy, output ready);
endinterface

// ===== rtl/core/cdq_cell.sv =====
// one storage cell of the queue row, shifts toward either neighbor
module cdq_cell (
  input  logic                               clk_i,
  input  cdq_pkg::cell_ctrl_t                ctrl_i,
  input  logic                               load_i,
  input  logic signed [cdq_pkg::WORD_W-1:0]  load_data_i,
  input  logic signed [cdq_pkg::WORD_W-1:0]  left_i,
  input  logic signed [cdq_pkg::WORD_W-1:0]  right_i,
  output logic signed [cdq_pkg::WORD_W-1:0]  data_o
);

  logic signed [cdq_pkg::WORD_W-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    if (load_i) begin
      data_d = load_data_i;
    end else if (ctrl_i.shift_r) begin
      data_d = left_i;
    end else if (ctrl_i.shift_l) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/core/circular_double_ended_queue.sv =====
// each result is registered in the cycle after its operation transaction
// throughput: one operation per cycle while the result side keeps taking transactions
// the front of the queue always sits in cell 0; pushes and pops at the front shift the row
// back pushes load the cell at the occupancy count, back pops read the cell below it
// reset clears the occupancy count and the result valid flag, cell contents are left as is
module circular_double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cdq_op_if.sink      in_i,
  cdq_res_if.source   out_o
);

  localparam int unsigned OCC_W = $clog2(DEPTH + 1);

  logic [OCC_W-1:0]                    count_d, count_q;
  logic                                out_valid_d, out_valid_q;
  logic signed [cdq_pkg::WORD_W-1:0]   value_d, value_q;
  cdq_pkg::status_e                    status_d, status_q;

  logic                                accept;
  logic                                is_push;
  logic                                full;
  logic                                empty;
  cdq_pkg::cell_ctrl_t                 ctrl;
  logic [DEPTH-1:0]                    load;
  logic [DEPTH-1:0]                    back_sel;
  logic signed [cdq_pkg::WORD_W-1:0]   cell_data [DEPTH];
  logic signed [cdq_pkg::WORD_W-1:0]   back_value;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign accept     = in_i.valid & in_i.ready;
  assign is_push    = (in_i.op == cdq_pkg::OP_PUSH_BACK) || (in_i.op == cdq_pkg::OP_PUSH_FRONT);
  assign full       = (count_q == OCC_W'(DEPTH));
  assign empty      = (count_q == '0);

  assign ctrl.shift_r = accept & (in_i.op == cdq_pkg::OP_PUSH_FRONT) & ~full;
  assign ctrl.shift_l = accept & (in_i.op == cdq_pkg::OP_POP_FRONT) & ~empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [cdq_pkg::WORD_W-1:0] left, right;

    assign load[i]     = accept & (in_i.op == cdq_pkg::OP_PUSH_BACK) & ~full
                         & (count_q == OCC_W'(i));
    assign back_sel[i] = (count_q == OCC_W'(i + 1));

    if (i == 0) begin : g_first
      assign left = in_i.data;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    cdq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .load_i      (load[i]),
      .load_data_i (in_i.data),
      .left_i      (left),
      .right_i     (right),
      .data_o      (cell_data[i])
    );
  end

  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_value = back_value | (cell_data[i] & {cdq_pkg::WORD_W{back_sel[i]}});
    end
  end

  always_comb begin
    count_d     = count_q;
    value_d     = value_q;
    status_d    = status_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    if (accept) begin
      out_valid_d = 1'b1;
      value_d     = '0;
      status_d    = cdq_pkg::ST_OK;
      if (is_push) begin
        if (full) begin
          status_d = cdq_pkg::ST_FULL;
        end else begin
          count_d = count_q + OCC_W'(1);
        end
      end else begin
        if (empty) begin
          status_d = cdq_pkg::ST_EMPTY;
          value_d  = cdq_pkg::EMPTY_VALUE;
        end else begin
          count_d = count_q - OCC_W'(1);
          value_d = (in_i.op == cdq_pkg::OP_POP_FRONT) ? cell_data[0] : back_value;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.value     = value_q;
  assign out_o.status    = status_q;
  assign out_o.occupancy = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= OCC_W'(DEPTH))
    else $error("occupancy beyond capacity");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == cdq_pkg::ST_FULL |-> count_q == OCC_W'(DEPTH))
    else $error("full status with room left");

  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == cdq_pkg::ST_EMPTY |-> count_q == '0 && value_q == '1)
    else $error("empty status with wrong occupancy or value");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_push && !full |=> count_q == $past(count_q) + OCC_W'(1))
    else $error("accepted push did not add an entry");

  a_shift_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({ctrl.shift_r, ctrl.shift_l, |load}) <= 1)
    else $error("conflicting cell commands");

endmodule
